[rtl/aacr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Altitude average and climb rate package
// Shared field widths, limits and the ring entry type.
// ----------------------------------------------------------------------------
package aacr_pkg;

    localparam int ALT_W            = 25;
    localparam int TS_W             = 32;
    localparam int RATE_W           = 21;
    localparam int RATE_LIMIT       = 1000000;
    localparam int WINDOW_DEPTH_DEF = 8;

    // Magnitude of an altitude difference times 1000 fits in 35 bits.
    localparam int MUL_W = ALT_W + 10;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic [TS_W-1:0]         ts;
        logic signed [ALT_W-1:0] alt;
    } aacr_entry_t;

endpackage

[rtl/aacr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/aacr_serdiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aacr_serdiv #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[rtl/altitude_average_and_climb_rate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Altitude average and climb rate
// Ring of the last altitude samples, ring mean and climb rate in cm/s.
// ----------------------------------------------------------------------------
// Each sample is stored relative to the ground offset in a ring memory with
// valid bits that reset clears. A sample with in_flight low only updates the
// ring and gives no beat. A sample with in_flight high goes through two ring
// reads and one multiply step; then the mean and the climb rate come out of
// two bit-serial dividers that run side by side, the 35-step climb rate
// divider being the longer, before its result beat is offered. The next sample
// is accepted while the previous result waits on the master side; the block
// holds in its last step only if that result is still not taken.
module altitude_average_and_climb_rate #(
    parameter int WINDOW_DEPTH = aacr_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [aacr_pkg::ALT_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: altitude_cm, timestamp_ms.
    input  logic [aacr_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: in_flight.
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: mean_altitude_cm, climb_rate_cms.
    output logic [aacr_pkg::M_TDATA_W-1:0] m_tdata,
    // Fields from bit 0: rate_valid.
    output logic                           m_tuser
);

    import aacr_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = ALT_W + $clog2(WINDOW_DEPTH);
    localparam int DEN_M_W = $clog2(WINDOW_DEPTH + 1);
    localparam int ENT_W   = $bits(aacr_entry_t);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD1  = 3'd1;
    localparam logic [2:0] ST_RD2  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [ALT_W-1:0]        offset_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic [IDX_W-1:0]        slot_next;
    logic [IDX_W-1:0]        slot_inc;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [WINDOW_DEPTH-1:0] valid_next;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    logic [ALT_W-1:0]        rel_reg;
    logic [ALT_W-1:0]        rel_next;
    logic [TS_W-1:0]         ts_reg;
    logic [TS_W-1:0]         ts_next;
    logic                    fly_reg;
    logic                    fly_next;
    logic [TS_W-1:0]         dt_reg;
    logic [TS_W-1:0]         dt_next;
    logic                    dh_neg_reg;
    logic                    dh_neg_next;
    logic [ALT_W-1:0]        dh_mag_reg;
    logic [ALT_W-1:0]        dh_mag_next;
    logic [ALT_W-1:0]        mean_reg;
    logic [ALT_W-1:0]        mean_next;
    logic [RATE_W-1:0]       rate_reg;
    logic [RATE_W-1:0]       rate_next;
    logic                    rv_reg;
    logic                    rv_next;

    logic                    accept;
    logic [ALT_W:0]          rel_wide;
    logic [ALT_W-1:0]        rel_sat;
    aacr_entry_t             rd_entry;
    aacr_entry_t             wr_entry;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ALT_W-1:0]        old_alt;
    logic [TS_W-1:0]         old_ts;
    logic [ALT_W:0]          dh_wide;
    logic [ALT_W:0]          dh_abs;
    logic [MUL_W-1:0]        num_rate;
    logic [SUM_W-1:0]        num_mean;
    logic                    div_start;
    logic                    busy_rate;
    logic                    busy_mean;
    logic [MUL_W-1:0]        quo_rate;
    logic [SUM_W-1:0]        quo_mean;
    logic [DEN_M_W-1:0]      rem_mean;
    logic [SUM_W-1:0]        mean_mag;
    logic [SUM_W-1:0]        mean_full;
    logic [RATE_W-1:0]       rate_mag;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign slot_inc = (slot_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + IDX_W'(1);

    assign rel_wide = {s_tdata[ALT_W-1], s_tdata[ALT_W-1:0]}
                    - {offset_reg[ALT_W-1], offset_reg};
    always_comb
    begin
        if (rel_wide[ALT_W] != rel_wide[ALT_W-1])
        begin
            rel_sat = rel_wide[ALT_W] ? {1'b1, {(ALT_W-1){1'b0}}} : {1'b0, {(ALT_W-1){1'b1}}};
        end
        else
        begin
            rel_sat = rel_wide[ALT_W-1:0];
        end
    end

    assign ram_we    = (state_reg == ST_RD1);
    assign ram_raddr = (state_reg == ST_RD1) ? slot_inc : slot_reg;
    assign wr_entry  = '{ts: ts_reg, alt: rel_reg};

    aacr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign old_alt = valid_reg[slot_reg] ? rd_entry.alt : '0;
    assign old_ts  = valid_reg[slot_reg] ? rd_entry.ts : '0;
    assign dh_wide = {rel_reg[ALT_W-1], rel_reg} - {old_alt[ALT_W-1], old_alt};
    assign dh_abs  = dh_wide[ALT_W] ? -dh_wide : dh_wide;

    // Times 1000 as 1024 - 16 - 8.
    assign num_rate = (MUL_W'(dh_mag_reg) << 10) - (MUL_W'(dh_mag_reg) << 4)
                    - (MUL_W'(dh_mag_reg) << 3);
    assign num_mean = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign div_start = (state_reg == ST_MUL);

    aacr_serdiv #(
        .NUM_W (MUL_W),
        .DEN_W (TS_W)
    ) u_div_rate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_rate),
        .den   (dt_reg),
        .busy  (busy_rate),
        .quo   (quo_rate),
        .rem   ()
    );

    aacr_serdiv #(
        .NUM_W (SUM_W),
        .DEN_W (DEN_M_W)
    ) u_div_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_mean),
        .den   (DEN_M_W'(WINDOW_DEPTH)),
        .busy  (busy_mean),
        .quo   (quo_mean),
        .rem   (rem_mean)
    );

    always_comb
    begin
        mean_mag  = quo_mean + SUM_W'(rem_mean != '0);
        mean_full = sum_reg[SUM_W-1] ? -mean_mag : quo_mean;
        if (quo_rate > MUL_W'(RATE_LIMIT))
        begin
            rate_mag = RATE_W'(RATE_LIMIT);
        end
        else
        begin
            rate_mag = quo_rate[RATE_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        valid_next     = valid_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        rel_next       = rel_reg;
        ts_next        = ts_reg;
        fly_next       = fly_reg;
        dt_next        = dt_reg;
        dh_neg_next    = dh_neg_reg;
        dh_mag_next    = dh_mag_reg;
        mean_next      = mean_reg;
        rate_next      = rate_reg;
        rv_next        = rv_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rel_next   = rel_sat;
                    ts_next    = s_tdata[ALT_W +: TS_W];
                    fly_next   = s_tuser;
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                sum_next = sum_reg + {{(SUM_W-ALT_W){rel_reg[ALT_W-1]}}, rel_reg}
                         - {{(SUM_W-ALT_W){old_alt[ALT_W-1]}}, old_alt};
                valid_next[slot_reg] = 1'b1;
                slot_next  = slot_inc;
                state_next = fly_reg ? ST_RD2 : ST_IDLE;
            end
            ST_RD2:
            begin
                dt_next     = ts_reg - old_ts;
                dh_neg_next = dh_wide[ALT_W];
                dh_mag_next = dh_abs[ALT_W-1:0];
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!busy_rate && !busy_mean)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    mean_next      = mean_full[ALT_W-1:0];
                    out_valid_next = 1'b1;
                    if (dt_reg == '0)
                    begin
                        rate_next = '0;
                        rv_next   = 1'b0;
                    end
                    else
                    begin
                        rate_next = dh_neg_reg ? -rate_mag : rate_mag;
                        rv_next   = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            slot_reg      <= '0;
            valid_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg    <= rel_next;
        ts_reg     <= ts_next;
        fly_reg    <= fly_next;
        dt_reg     <= dt_next;
        dh_neg_reg <= dh_neg_next;
        dh_mag_reg <= dh_mag_next;
        mean_reg   <= mean_next;
        rate_reg   <= rate_next;
        rv_reg     <= rv_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-ALT_W-RATE_W){1'b0}}, rate_reg, mean_reg};
    assign m_tuser  = rv_reg;

endmodule

[rtl/aacr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Altitude average and climb rate checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module aacr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [aacr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    import aacr_pkg::*;

    logic signed [RATE_W-1:0] rate_out;

    assign rate_out = $signed(m_tdata[ALT_W +: RATE_W]);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The block works on one sample at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while another is in work");

    // No result can appear in the cycle after a sample is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // An invalid rate is reported as zero.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> rate_out == '0)
        else $error("invalid climb rate is not zero");

    // The climb rate stays within its saturation limits.
    a_rate_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (rate_out <= RATE_W'(RATE_LIMIT)) && (rate_out >= -RATE_W'(RATE_LIMIT)))
        else $error("climb rate beyond limit");

endmodule

bind altitude_average_and_climb_rate aacr_checker u_aacr_checker (.*);

[bench/tb_altitude_average_and_climb_rate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Altitude average and climb rate testbench
// Drives altitude samples into the block, predicts each result beat and
// compares it field by field, with random idling on both streams.
// ----------------------------------------------------------------------------
// A short directed part covers the field extremes, the empty ring, time that
// wraps or stands still, and both kinds of saturation. Random flights follow
// in several ground-offset phases. Each flight is mostly a well-formed climb
// and descent, with noise beats mixed in.
module tb_altitude_average_and_climb_rate;

    import aacr_pkg::*;

    localparam int     WINDOW      = WINDOW_DEPTH_DEF;
    localparam int     MEAN_SHIFT  = $clog2(WINDOW);
    localparam longint ALT_MAX     = (64'sd1 <<< (ALT_W - 1)) - 1;
    localparam longint ALT_MIN     = -ALT_MAX - 1;
    localparam longint MS_PER_S    = 1000;
    localparam int     DRAIN_TAIL  = 60;
    localparam int     CYCLE_LIMIT = 500000;
    localparam int     PHASE_BEATS = 100;

    typedef struct {
        logic signed [ALT_W-1:0]  mean;
        logic signed [RATE_W-1:0] rate;
        logic                     valid;
    } climb_result_t;

    class climb_scoreboard;
        longint        offset_cm;
        longint        ring_alt [WINDOW];
        logic [31:0]   ring_ts [WINDOW];
        int unsigned   next_slot;
        longint        ring_sum;
        climb_result_t expected_results [$];
        int            mismatches;

        function new();
            offset_cm  = 0;
            next_slot  = 0;
            ring_sum   = 0;
            mismatches = 0;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_alt[i] = 0;
                ring_ts[i]  = '0;
            end
        endfunction

        function void set_offset(logic signed [ALT_W-1:0] value);
            offset_cm = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_sample(logic signed [ALT_W-1:0] alt, logic [31:0] ts,
                                  bit in_flight);
            longint        rel;
            longint        dh;
            longint        rate;
            logic [31:0]   dt;
            int unsigned   slot;
            int unsigned   oldest;
            climb_result_t res;
            rel = longint'(alt) - offset_cm;
            if (rel < ALT_MIN)
                rel = ALT_MIN;
            if (rel > ALT_MAX)
                rel = ALT_MAX;
            slot = next_slot;
            ring_sum += rel - ring_alt[slot];
            ring_alt[slot] = rel;
            ring_ts[slot]  = ts;
            oldest = (slot + 1) % WINDOW;
            next_slot = oldest;
            if (!in_flight)
                return;
            res.mean = ring_sum >>> MEAN_SHIFT;
            dt = ts - ring_ts[oldest];
            dh = rel - ring_alt[oldest];
            if (dt == 0)
            begin
                res.rate  = '0;
                res.valid = 1'b0;
            end
            else
            begin
                rate = (dh * MS_PER_S) / longint'(dt);
                if (rate > RATE_LIMIT)
                    rate = RATE_LIMIT;
                if (rate < -RATE_LIMIT)
                    rate = -RATE_LIMIT;
                res.rate  = rate;
                res.valid = 1'b1;
            end
            expected_results.push_back(res);
        endfunction

        function void report(string what, longint exp_value, longint act_value);
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s: expected %0d, got %0d", what, exp_value,
                         act_value);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic user);
            climb_result_t           res;
            logic signed [ALT_W-1:0]  got_mean;
            logic signed [RATE_W-1:0] got_rate;
            got_mean = data[ALT_W-1:0];
            got_rate = data[ALT_W+RATE_W-1:ALT_W];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result beat with none expected: mean %0d, rate %0d",
                             got_mean, got_rate);
                return;
            end
            res = expected_results.pop_front();
            if (got_mean !== res.mean)
                report("mean_altitude_cm", res.mean, got_mean);
            if (got_rate !== res.rate)
                report("climb_rate_cms", res.rate, got_rate);
            if (user !== res.valid)
                report("rate_valid", res.valid, user);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [ALT_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    climb_scoreboard board = new();
    bit              send_burst;
    bit              recv_burst;
    int              cycle_count;

    altitude_average_and_climb_rate dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic int random_altitude();
        int v;
        if ($urandom_range(0, 3) == 0)
        begin
            v = $urandom();
            return (v <<< 7) >>> 7;
        end
        return int'($urandom_range(0, 11000000)) - 1000000;
    endfunction

    task automatic send_sample(input int alt, input logic [31:0] ts, input bit in_flight);
        int                      gap;
        logic signed [ALT_W-1:0] alt_f;
        alt_f = alt[ALT_W-1:0];
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ALT_W - TS_W){1'b0}}, ts, alt_f};
        s_tuser  <= in_flight;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_sample(alt_f, ts, in_flight);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_offset(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[ALT_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_offset(value[ALT_W-1:0]);
    endtask

    task automatic run_flight(input int count, input int base_offset);
        int          ground;
        int          alt;
        int          climb;
        int          liftoff;
        logic [31:0] ts;
        if ($urandom_range(0, 3) == 0)
            ts = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else
            ts = $urandom();
        ground  = base_offset + int'($urandom_range(0, 400)) - 200;
        alt     = ground;
        climb   = $urandom_range(500, 3000);
        liftoff = $urandom_range(3, 12);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(random_altitude(), $urandom(), $urandom_range(0, 1));
            else
            begin
                ts += $urandom_range(0, 15);
                if (k >= liftoff)
                begin
                    alt   += climb;
                    climb -= int'($urandom_range(0, 120));
                end
                else
                    alt = ground + int'($urandom_range(0, 100)) - 50;
                if (alt > 10000000)
                    alt = 10000000;
                if (alt < -1000000)
                    alt = -1000000;
                send_sample(alt, ts, k >= liftoff);
            end
            if ($urandom_range(0, 60) == 0)
                wait_results();
        end
    endtask

    initial
    begin
        forever
        begin
            int stall;
            stall = draw_wait(recv_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            board.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        int phase_offset [5];
        int remaining;
        int n;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_offset(0);
        send_sample(0, 32'd0, 1'b1);
        send_sample(10000000, 32'd1, 1'b1);
        send_sample(-1000000, 32'd2, 1'b0);
        send_sample(-1000000, 32'hFFFF_FFFF, 1'b1);
        send_sample(1234, 32'h0000_0010, 1'b1);
        send_sample(-1, 32'd20, 1'b1);
        send_sample(7, 32'd30, 1'b1);
        send_sample(8, 32'd40, 1'b1);
        send_sample(9, 32'd0, 1'b1);
        send_sample(100, 32'd2, 1'b1);
        settle();
        write_offset(-16777216);
        send_sample(16777215, 32'd50, 1'b1);
        send_sample(-16777216, 32'd51, 1'b1);
        settle();
        write_offset(16777215);
        send_sample(-16777216, 32'd52, 1'b1);
        send_sample(16777215, 32'd53, 1'b0);
        settle();
        write_offset(10000000);
        send_sample(-1000000, 32'd60, 1'b1);
        settle();
        write_offset(-1000000);
        send_sample(10000000, 32'd61, 1'b1);

        phase_offset[0] = 0;
        phase_offset[1] = -1000000;
        phase_offset[2] = 10000000;
        phase_offset[3] = int'($urandom_range(0, 11000000)) - 1000000;
        phase_offset[4] = int'($urandom_range(0, 11000000)) - 1000000;
        foreach (phase_offset[p])
        begin
            settle();
            write_offset(phase_offset[p]);
            remaining = PHASE_BEATS;
            while (remaining > 0)
            begin
                n = $urandom_range(15, 50);
                if (n > remaining)
                    n = remaining;
                run_flight(n, phase_offset[p]);
                remaining -= n;
            end
        end

        wait_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
